@@ rtl/sapk_pkg.sv @@
// ============================================================================
// sapk_pkg: shared types and constants of the six-bit ASCII field packer
// Field limits, RAM geometry, job descriptor and state encodings.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package sapk_pkg;

    localparam int MAX_FIELD_BYTES = 63;
    localparam int CHAR_LIMIT      = (MAX_FIELD_BYTES * 8) / 6;
    localparam int CHAR_W          = $clog2(CHAR_LIMIT + 1);
    localparam int BYTE_IDX_W      = $clog2(MAX_FIELD_BYTES + 1);
    localparam int BANK_DEPTH      = 1 << BYTE_IDX_W;
    localparam int RAM_DEPTH       = 2 * BANK_DEPTH;
    localparam int RAM_AW          = BYTE_IDX_W + 1;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_AW        = 1;
    localparam int QUEUE_CW        = 2;

    localparam logic [7:0] CODE_OFFSET = 8'h20;
    localparam logic [7:0] TYPE_ASCII6 = 8'h80;

    typedef struct packed {
        logic                  ovf;
        logic [BYTE_IDX_W-1:0] n;
        logic                  bank;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } ram_wr_t;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
    } ram_rd_t;

    typedef enum logic {
        FR_COLLECT,
        FR_CLOSE
    } front_state_t;

    typedef enum logic {
        BK_IDLE,
        BK_SEND
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/sapk_ram.sv @@
// ============================================================================
// sapk_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sapk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/sapk_front.sv @@
// ============================================================================
// sapk_front: character intake and bit packer
// Turns characters into 6-bit codes, packs them LSB first into the RAM bank
// being filled, and queues a job for the drain side at the end of a field.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sapk_front
    import sapk_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    input  wire logic       q_full,
    output logic            q_push,
    output job_t            q_job,
    output ram_wr_t         ram_wr
);

    front_state_t          state_reg, state_next;
    logic [5:0]            res_reg, res_next;
    logic [2:0]            rc_reg, rc_next;
    logic [BYTE_IDX_W-1:0] bcnt_reg, bcnt_next;
    logic [CHAR_W-1:0]     ccnt_reg, ccnt_next;
    logic                  ovf_reg, ovf_next;
    logic                  bank_reg, bank_next;

    logic [7:0]  diff;
    logic [5:0]  code;
    logic [11:0] acc;
    logic [3:0]  bits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_COLLECT;
            res_reg   <= '0;
            rc_reg    <= '0;
            bcnt_reg  <= '0;
            ccnt_reg  <= '0;
            ovf_reg   <= 1'b0;
            bank_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
            rc_reg    <= rc_next;
            bcnt_reg  <= bcnt_next;
            ccnt_reg  <= ccnt_next;
            ovf_reg   <= ovf_next;
            bank_reg  <= bank_next;
        end
    end

    always_comb begin
        diff = s_tdata - CODE_OFFSET;
        code = diff[5:0];
        acc  = {6'd0, res_reg} | ({6'd0, code} << rc_reg);
        bits = {1'b0, rc_reg} + 4'd6;

        state_next = state_reg;
        res_next   = res_reg;
        rc_next    = rc_reg;
        bcnt_next  = bcnt_reg;
        ccnt_next  = ccnt_reg;
        ovf_next   = ovf_reg;
        bank_next  = bank_reg;
        s_tready   = 1'b0;
        q_push     = 1'b0;
        q_job      = '{ovf: ovf_reg, n: bcnt_reg, bank: bank_reg};
        ram_wr     = '{en: 1'b0, addr: {bank_reg, bcnt_reg}, data: acc[7:0]};

        unique case (state_reg)
            FR_COLLECT: begin
                s_tready = !q_full;
                if (s_tvalid && !q_full) begin
                    if (ccnt_reg >= CHAR_W'(CHAR_LIMIT)) begin
                        // field full: drop the character
                        ovf_next = 1'b1;
                    end else begin
                        ccnt_next = ccnt_reg + 1'b1;
                        if (bits >= 4'd8) begin
                            ram_wr.en = 1'b1;
                            bcnt_next = bcnt_reg + 1'b1;
                            res_next  = {2'd0, acc[11:8]};
                            rc_next   = 3'(bits - 4'd8);
                        end else begin
                            res_next = acc[5:0];
                            rc_next  = 3'(bits);
                        end
                    end
                    if (s_tlast) begin
                        state_next = FR_CLOSE;
                    end
                end
            end
            FR_CLOSE: begin
                // flush pending bits, hand the bank to the drain side
                if (rc_reg != 3'd0) begin
                    ram_wr.en   = 1'b1;
                    ram_wr.data = {2'd0, res_reg};
                    q_job.n     = bcnt_reg + 1'b1;
                end
                q_push     = 1'b1;
                res_next   = '0;
                rc_next    = '0;
                bcnt_next  = '0;
                ccnt_next  = '0;
                ovf_next   = 1'b0;
                bank_next  = !bank_reg;
                state_next = FR_COLLECT;
            end
            default: state_next = FR_COLLECT;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/sapk_job_fifo.sv @@
// ============================================================================
// sapk_job_fifo: two-entry queue of finished fields
// Holds one job per packed RAM bank until the drain side has sent it.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sapk_job_fifo
    import sapk_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  job_t      push_job,
    input  wire logic pop,
    output job_t      head,
    output logic      full,
    output logic      empty
);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;

    assign full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/sapk_back.sv @@
// ============================================================================
// sapk_back: field drain
// Sends the type/length byte and then the packed bytes of the head job,
// with a running zero checksum, one word per accepted transfer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sapk_back
    import sapk_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  job_t            q_head,
    input  wire logic       q_empty,
    output logic            q_pop,
    output ram_rd_t         ram_rd,
    input  wire logic [7:0] ram_rdata,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [15:0]     m_tdata,
    output logic            m_tlast,
    output logic [1:0]      m_tuser
);

    back_state_t           state_reg, state_next;
    logic [BYTE_IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]            byte_reg, byte_next;
    logic [7:0]            chk_reg, chk_next;
    logic                  hdr_reg, hdr_next;
    logic                  last_reg, last_next;
    logic                  ovf_reg, ovf_next;

    logic [7:0]            hdr_byte;
    logic [BYTE_IDX_W:0]   idx_inc;

    assign m_tvalid = (state_reg == BK_SEND);
    assign m_tdata  = {chk_reg, byte_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = {ovf_reg, hdr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        byte_reg <= byte_next;
        chk_reg  <= chk_next;
        hdr_reg  <= hdr_next;
        last_reg <= last_next;
        ovf_reg  <= ovf_next;
    end

    always_comb begin
        hdr_byte = TYPE_ASCII6 | {{(8 - BYTE_IDX_W){1'b0}}, q_head.n};
        idx_inc  = {1'b0, idx_reg} + 1'b1;

        state_next = state_reg;
        idx_next   = idx_reg;
        byte_next  = byte_reg;
        chk_next   = chk_reg;
        hdr_next   = hdr_reg;
        last_next  = last_reg;
        ovf_next   = ovf_reg;
        q_pop      = 1'b0;
        ram_rd     = '{en: 1'b0, addr: {q_head.bank, idx_reg}};

        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    byte_next  = hdr_byte;
                    chk_next   = 8'd0 - hdr_byte;
                    hdr_next   = 1'b1;
                    last_next  = (q_head.n == '0);
                    ovf_next   = q_head.ovf;
                    idx_next   = '0;
                    // prefetch the first packed byte
                    ram_rd     = '{en: 1'b1, addr: {q_head.bank, {BYTE_IDX_W{1'b0}}}};
                    state_next = BK_SEND;
                end
            end
            BK_SEND: begin
                if (m_tready) begin
                    if (last_reg) begin
                        q_pop      = 1'b1;
                        state_next = BK_IDLE;
                    end else begin
                        byte_next = ram_rdata;
                        chk_next  = chk_reg - ram_rdata;
                        hdr_next  = 1'b0;
                        last_next = (idx_inc == {1'b0, q_head.n});
                        idx_next  = idx_inc[BYTE_IDX_W-1:0];
                        ram_rd    = '{en: 1'b1,
                                      addr: {q_head.bank, idx_inc[BYTE_IDX_W-1:0]}};
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/sixbit_ascii_field_packer_core.sv @@
// ============================================================================
// sixbit_ascii_field_packer_core: 6-bit ASCII packed text field encoder
// Packs the characters of a text field and streams the encoded field.
// ============================================================================
// Usage:
//   s_ channel: one character per word in s_tdata[7:0]; s_tlast marks the
//   last character of the field. Characters beyond 84 are dropped.
//   m_ channel: the type/length byte, then the packed bytes. m_tdata[7:0]
//   is the byte, m_tdata[15:8] the running zero checksum; m_tuser[0] marks
//   the type/length byte, m_tuser[1] flags a field that lost characters;
//   m_tlast marks the final byte of the field.
//   Throughput: one character per cycle into the packer while s_tready is
//   high. After the last character every field passes a close state, input
//   held off, that flushes any pending bits. A field of n packed bytes
//   drains in n + 1 words at one word per cycle while m_tready is high.
//   Two RAM banks let the next field pack while the previous one drains;
//   s_tready drops in the close state and while both banks hold fields
//   not yet sent.
//   Reset: synchronous, active low; clears state, queue and field counters.
//   Receiver stall: the current word holds; packing goes on until both
//   banks are taken.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sixbit_ascii_field_packer_core
    import sapk_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [7:0] out_byte, [15:8] zero_checksum
    output logic             m_tlast,
    output logic      [1:0]  m_tuser    // [0] is_header, [1] overflow
);

    logic    q_push, q_pop, q_full, q_empty;
    job_t    q_job, q_head;
    ram_wr_t ram_wr;
    ram_rd_t ram_rd;
    logic [7:0] ram_rdata;

    sapk_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job),
        .ram_wr   (ram_wr)
    );

    sapk_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_wr.en),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .re    (ram_rd.en),
        .raddr (ram_rd.addr),
        .rdata (ram_rdata)
    );

    sapk_job_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    sapk_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .ram_rd    (ram_rd),
        .ram_rdata (ram_rdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
